>>> design/dss_pkg.sv
// types, constants and calendar helpers for the datetime shift block
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

    localparam int YEAR_BITS = 12;
    localparam int YR_W      = YEAR_BITS + 2;
    localparam int MOD_STEPS = YEAR_BITS - 8;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] LAST_SEC_DAY  = 17'd86399;
    localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_REWIND  = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [4:0]           day;
        logic [3:0]           month;
        logic [YEAR_BITS-1:0] year;
        logic [4:0]           hour;
        logic [5:0]           minute;
        logic [5:0]           second;
        logic [30:0]          shift_amount;
    } dss_in_t;

    typedef struct packed {
        logic [4:0]           new_day;
        logic [3:0]           new_month;
        logic [YEAR_BITS-1:0] new_year;
        logic [4:0]           new_hour;
        logic [5:0]           new_minute;
        logic [5:0]           new_second;
        logic                 year_overflow;
    } dss_out_t;

    // argument is the year modulo 400
    function automatic logic is_leap(input logic [8:0] y400);
        return (y400 == 9'd0) ||
               ((y400[1:0] == 2'b00) && (y400 != 9'd100) &&
                (y400 != 9'd200) && (y400 != 9'd300));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    // days from 1 march to the first of month m
    function automatic logic [8:0] march_offset(input logic [3:0] m);
        logic [8:0] off;
        case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    // month lengths counted from march, february last and never tested
    function automatic logic [4:0] march_month_len(input logic [3:0] mp);
        logic [4:0] len;
        case (mp) inside
            4'd1, 4'd3, 4'd6, 4'd8: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> design/datetime_shift_seconds.sv
// top level: gregorian timestamp shifted forward or backward by a second count
`timescale 1ns / 1ps
`default_nettype none

// One item is in flight at a time. A small sequencer runs the steps in order: year
// modulo 400 and division of the shifted time by 86400 on one shared 32-bit
// compare-subtract unit, a day-count walk of one calendar year per cycle, as long
// as the span of the shift demands, a walk of one month per cycle on the same unit,
// then hour and minute digits on it as well. The year walk dominates. A finished
// result sits in an output register, so the next item is taken while that result
// still waits to be read.
module datetime_shift_seconds (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  dss_pkg::dss_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output dss_pkg::dss_out_t m_data
);
    import dss_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_PREP,
        ST_DIV,
        ST_LOAD,
        ST_YEAR,
        ST_MON,
        ST_HOUR,
        ST_MIN,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    dss_in_t                in_reg;
    logic [31:0]            rem_reg;
    logic [3:0]             step_reg;
    logic [15:0]            q_reg;
    logic [16:0]            tod_reg;
    logic signed [16:0]     doy_reg;
    logic signed [YR_W-1:0] yy_reg;
    logic [8:0]             y400_reg;
    logic [3:0]             mp_reg;
    logic [4:0]             hour_reg;
    logic [5:0]             min_reg;
    logic                   m_valid_reg;
    dss_out_t               m_data_reg;

    // shared compare-subtract unit
    logic [31:0] opa;
    logic [31:0] opb;
    logic [32:0] diff;
    logic        ge;

    always_comb begin
        opa = rem_reg;
        opb = '0;
        case (state_reg)
            ST_MOD:  opb = 32'(YEARS_PER_ERA) << step_reg;
            ST_DIV:  opb = 32'(SECS_PER_DAY) << step_reg;
            ST_HOUR: opb = 32'(SECS_PER_HOUR) << step_reg;
            ST_MIN:  opb = 32'(SECS_PER_MIN) << step_reg;
            ST_MON: begin
                opa = 32'(doy_reg[15:0]);
                opb = 32'(march_month_len(mp_reg));
            end
            default: opb = '0;
        endcase
        diff = {1'b0, opa} - {1'b0, opb};
        ge   = ~diff[32];
    end

    // input correction and start values
    logic [8:0]  ymod;
    logic [3:0]  m_c;
    logic [4:0]  ml;
    logic [4:0]  d_c;
    logic [4:0]  hh_c;
    logic [5:0]  mi_c;
    logic [5:0]  ss_c;
    logic [16:0] tod0;
    logic [31:0] x_start;
    logic        early;
    logic [8:0]  ymod_next;

    always_comb begin
        ymod = rem_reg[8:0];
        if (in_reg.month == 4'd0) begin
            m_c = 4'd1;
        end else if (in_reg.month > 4'd12) begin
            m_c = 4'd12;
        end else begin
            m_c = in_reg.month;
        end
        ml = month_len(m_c, is_leap(ymod));
        if (in_reg.day == 5'd0) begin
            d_c = 5'd1;
        end else if (in_reg.day > ml) begin
            d_c = ml;
        end else begin
            d_c = in_reg.day;
        end
        hh_c = (in_reg.hour > 5'd23) ? 5'd23 : in_reg.hour;
        mi_c = (in_reg.minute > 6'd59) ? 6'd59 : in_reg.minute;
        ss_c = (in_reg.second > 6'd59) ? 6'd59 : in_reg.second;
        tod0 = 17'(hh_c) * 17'(SECS_PER_HOUR) + 17'(mi_c) * 17'(SECS_PER_MIN)
             + 17'(ss_c);
        if (in_reg.opcode == OP_REWIND) begin
            x_start = 32'(in_reg.shift_amount) + 32'(LAST_SEC_DAY) - 32'(tod0);
        end else begin
            x_start = 32'(in_reg.shift_amount) + 32'(tod0);
        end
        early     = (m_c <= 4'd2);
        ymod_next = (ymod == YEARS_PER_ERA - 9'd1) ? 9'd0 : ymod + 9'd1;
    end

    // year walk
    logic [8:0]  y400_prev;
    logic [8:0]  y400_succ;
    logic [8:0]  cur_len;
    logic [8:0]  prev_len;

    always_comb begin
        y400_prev = (y400_reg == 9'd0) ? YEARS_PER_ERA - 9'd1 : y400_reg - 9'd1;
        y400_succ = (y400_reg == YEARS_PER_ERA - 9'd1) ? 9'd0 : y400_reg + 9'd1;
        cur_len   = 9'd365 + 9'(is_leap(y400_reg));
        prev_len  = 9'd365 + 9'(is_leap(y400_prev));
    end

    // result assembly
    logic [3:0]             mon_out;
    logic signed [YR_W-1:0] y_out;
    dss_out_t               res;

    always_comb begin
        mon_out = (mp_reg < 4'd10) ? mp_reg + 4'd3 : mp_reg - 4'd9;
        y_out   = yy_reg + $signed(YR_W'(mp_reg >= 4'd10));
        res.new_day       = doy_reg[4:0] + 5'd1;
        res.new_month     = mon_out;
        res.new_year      = y_out[YEAR_BITS-1:0];
        res.new_hour      = hour_reg;
        res.new_minute    = min_reg;
        res.new_second    = rem_reg[5:0];
        res.year_overflow = |y_out[YR_W-1:YEAR_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        rem_reg   <= 32'(s_data.year);
                        step_reg  <= 4'(MOD_STEPS - 1);
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (ge) begin
                        rem_reg <= diff[31:0];
                    end
                    if (step_reg == 4'd0) begin
                        state_reg <= ST_PREP;
                    end else begin
                        step_reg <= step_reg - 4'd1;
                    end
                end
                ST_PREP: begin
                    rem_reg   <= x_start;
                    step_reg  <= 4'd15;
                    q_reg     <= '0;
                    doy_reg   <= $signed(17'(march_offset(m_c)) + 17'(d_c) - 17'd1);
                    yy_reg    <= $signed({2'b00, in_reg.year} - YR_W'(early));
                    y400_reg  <= early ? ymod : ymod_next;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    q_reg <= {q_reg[14:0], ge};
                    if (ge) begin
                        rem_reg <= diff[31:0];
                    end
                    if (step_reg == 4'd0) begin
                        state_reg <= ST_LOAD;
                    end else begin
                        step_reg <= step_reg - 4'd1;
                    end
                end
                ST_LOAD: begin
                    if (in_reg.opcode == OP_REWIND) begin
                        tod_reg <= LAST_SEC_DAY - rem_reg[16:0];
                        doy_reg <= doy_reg - $signed(17'(q_reg));
                    end else begin
                        tod_reg <= rem_reg[16:0];
                        doy_reg <= doy_reg + $signed(17'(q_reg));
                    end
                    state_reg <= ST_YEAR;
                end
                ST_YEAR: begin
                    if (doy_reg < 0) begin
                        doy_reg  <= doy_reg + $signed(17'(prev_len));
                        yy_reg   <= yy_reg - $signed(YR_W'(1));
                        y400_reg <= y400_prev;
                    end else if (doy_reg >= $signed(17'(cur_len))) begin
                        doy_reg  <= doy_reg - $signed(17'(cur_len));
                        yy_reg   <= yy_reg + $signed(YR_W'(1));
                        y400_reg <= y400_succ;
                    end else begin
                        mp_reg    <= '0;
                        state_reg <= ST_MON;
                    end
                end
                ST_MON: begin
                    if ((mp_reg < 4'd11) && ge) begin
                        doy_reg <= $signed(diff[16:0]);
                        mp_reg  <= mp_reg + 4'd1;
                    end else begin
                        rem_reg   <= 32'(tod_reg);
                        step_reg  <= 4'd4;
                        state_reg <= ST_HOUR;
                    end
                end
                ST_HOUR: begin
                    hour_reg <= {hour_reg[3:0], ge};
                    if (ge) begin
                        rem_reg <= diff[31:0];
                    end
                    if (step_reg == 4'd0) begin
                        step_reg  <= 4'd5;
                        state_reg <= ST_MIN;
                    end else begin
                        step_reg <= step_reg - 4'd1;
                    end
                end
                ST_MIN: begin
                    min_reg <= {min_reg[4:0], ge};
                    if (ge) begin
                        rem_reg <= diff[31:0];
                    end
                    if (step_reg == 4'd0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        step_reg <= step_reg - 4'd1;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> design/dss_checker.sv
// port checker for the datetime shift block and its bind
`timescale 1ns / 1ps
`default_nettype none

module dss_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               s_valid,
    input wire               s_ready,
    input wire               m_valid,
    input wire               m_ready,
    input dss_pkg::dss_out_t m_data
);
    import dss_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // busy once an item is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken again too soon");

    // a new result only appears after a busy spell
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without work");

    // fields of a result lie in their legal ranges
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.new_month >= 4'd1 && m_data.new_month <= 4'd12 &&
                    m_data.new_day >= 5'd1 && m_data.new_day <= 5'd31 &&
                    (m_data.new_month != 4'd2 || m_data.new_day <= 5'd29) &&
                    m_data.new_hour <= 5'd23 && m_data.new_minute <= 6'd59 &&
                    m_data.new_second <= 6'd59)
        else $error("result out of range");

endmodule

bind datetime_shift_seconds dss_checker u_dss_checker (.*);

`default_nettype wire
